/* rtl/psfc_pkg.sv */
// Shared types and defaults for the prime sieve filter chain.
// Used by psfc_cell, prime_sieve_filter_chain, prime_stream_checker and the testbench; depends on nothing.
package psfc_pkg;

  // Width of the value and prime fields on the ports
  localparam int FIELD_W = 16;

  // Default chain length and candidate width
  localparam int STAGES_DEF      = 16;
  localparam int VALUE_WIDTH_DEF = 16;

  // One candidate bit moving down the chain, MSB first
  typedef struct packed {
    logic valid;
    logic dbit;
    logic last;   // final bit of the candidate
    logic hit;    // some cell upstream divides the candidate
  } token_t;

  // Per-cell control from the top level
  typedef struct packed {
    logic               active;  // cell holds a stored prime
    logic               load;    // write prime into this cell
    logic [FIELD_W-1:0] prime;
  } cell_ctl_t;

endpackage

/* rtl/prime_sieve_filter_chain.sv */
// Prime sieve filter chain: top level, sequencer and prime count (uses psfc_pkg, psfc_cell).
// Each candidate is min(VALUE_WIDTH, 16) bits wide and is shifted MSB first through the cells;
// values below two are accepted with no result. A new candidate is taken only once the last one
// has left the chain and any result has been emitted, which waits while a stalled earlier result
// holds the output.
// Reset (synchronous, rst high) empties the prime table; stored primes hold no reset.
module prime_sieve_filter_chain #(
  parameter int STAGES      = psfc_pkg::STAGES_DEF,
  parameter int VALUE_WIDTH = psfc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [psfc_pkg::FIELD_W-1:0] value,
  input  logic                         restart,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [psfc_pkg::FIELD_W-1:0] prime,
  output logic                         unverified
);
  import psfc_pkg::*;

  localparam int VW  = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
  localparam int CW  = $clog2(STAGES + 1);
  localparam int BCW = $clog2(VW);
  localparam logic [CW-1:0]  FULL_CNT = CW'(STAGES);
  localparam logic [BCW-1:0] LAST_BIT = BCW'(VW - 1);

  typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [VW-1:0]   cand;
  logic [VW-1:0]   shreg;
  logic [BCW-1:0]  bitcnt;
  logic            injecting;
  logic            survivor;
  logic            emit;
  logic            load_en;
  logic [VW-1:0]   v_in;
  logic            in_fire;
  logic            out_free;
  logic            full;

  token_t    tok [STAGES+1];
  cell_ctl_t ctl [STAGES];

  assign v_in     = value[VW-1:0];
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign full     = (count >= FULL_CNT);
  assign in_stall = (state != IDLE);
  assign emit     = (state == DONE) && survivor && out_free;
  assign load_en  = emit && !full;

  // Feed the candidate into the chain MSB first
  always_comb begin
    tok[0].valid = (state == RUN) && injecting;
    tok[0].dbit  = shreg[VW-1];
    tok[0].last  = (bitcnt == LAST_BIT);
    tok[0].hit   = 1'b0;
  end

  // Row of cells, one stored prime each
  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    always_comb begin
      ctl[i].active = (count > IDX);
      ctl[i].load   = load_en && (count == IDX);
      ctl[i].prime  = FIELD_W'(cand);
    end
    psfc_cell #(.VW(VW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .ctl     (ctl[i]),
      .tok_out (tok[i+1])
    );
  end

  // Sequencer, prime count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      injecting <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Raise valid on an emitted beat, drop it once taken
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_fire) begin
            if (restart) begin
              count <= '0;
            end
            if (v_in >= VW'(2)) begin
              cand      <= v_in;
              shreg     <= v_in;
              bitcnt    <= '0;
              injecting <= 1'b1;
              state     <= RUN;
            end
          end
        end
        RUN: begin
          if (injecting) begin
            shreg  <= {shreg[VW-2:0], 1'b0};
            bitcnt <= bitcnt + BCW'(1);
            if (bitcnt == LAST_BIT) begin
              injecting <= 1'b0;
            end
          end
          if (tok[STAGES].valid && tok[STAGES].last) begin
            survivor <= !tok[STAGES].hit;
            state    <= DONE;
          end
        end
        DONE: begin
          if (!survivor) begin
            state <= IDLE;
          end else if (out_free) begin
            prime      <= FIELD_W'(cand);
            unverified <= full;
            if (!full) begin
              count <= count + CW'(1);
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // Checks on the sequencer and table
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("prime count beyond chain length");

  a_tail_in_run: assert property (@(posedge clk) disable iff (rst)
    tok[STAGES].valid |-> state == RUN)
    else $error("chain beat outside a run");

  a_load_room: assert property (@(posedge clk) disable iff (rst)
    load_en |=> count != '0 && $past(count) < FULL_CNT)
    else $error("append to a full table");

  a_start_run: assert property (@(posedge clk) disable iff (rst)
    in_fire && v_in >= VW'(2) |=> state == RUN && injecting)
    else $error("candidate did not start a run");

endmodule

/* rtl/psfc_cell.sv */
// One cell of the sieve chain: holds a prime and a bit-serial remainder.
// Depends on psfc_pkg (token_t, cell_ctl_t).
module psfc_cell #(
  parameter int VW = psfc_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  psfc_pkg::token_t   tok_in,
  input  psfc_pkg::cell_ctl_t ctl,
  output psfc_pkg::token_t   tok_out
);
  import psfc_pkg::*;

  logic [VW-1:0] p;
  logic [VW-1:0] rem;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;
  logic          ge;
  logic [VW-1:0] rem_next;
  logic          divides;

  // One restoring-division step on the incoming bit
  always_comb begin
    shifted  = {rem, tok_in.dbit};
    diff     = shifted - {1'b0, p};
    ge       = (shifted >= {1'b0, p});
    rem_next = ge ? diff[VW-1:0] : shifted[VW-1:0];
    divides  = tok_in.last && ctl.active && (rem_next == '0);
  end

  // Store the prime when the top level appends it
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      p <= ctl.prime[VW-1:0];
    end
  end

  // Advance the remainder and hand the beat to the next cell
  always_ff @(posedge clk) begin
    tok_out.dbit <= tok_in.dbit;
    tok_out.last <= tok_in.last;
    tok_out.hit  <= tok_in.hit | divides;
    if (rst) begin
      rem           <= '0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
      if (tok_in.valid) begin
        rem <= tok_in.last ? '0 : rem_next;
      end
    end
  end

endmodule

/* verif/prime_stream_checker.sv */
// Checker for the prime sieve filter chain: watches both channels, predicts each result
// from its own copy of the prime table and compares it with what the block emits.
// Depends on psfc_pkg for the field width and the default parameters.
module prime_stream_checker #(
  parameter int STAGES      = psfc_pkg::STAGES_DEF,
  parameter int VALUE_WIDTH = psfc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [psfc_pkg::FIELD_W-1:0] value,
  input  logic                         restart,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [psfc_pkg::FIELD_W-1:0] prime,
  input  logic                         unverified,
  output int                           fails,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [psfc_pkg::FIELD_W-1:0] field_t;

  typedef struct packed {
    field_t prime;
    logic   unverified;
  } sieve_result_t;

  // Candidates wider than the port are cut to the port width
  localparam int     VW         = (VALUE_WIDTH < psfc_pkg::FIELD_W) ? VALUE_WIDTH
                                                                    : psfc_pkg::FIELD_W;
  localparam field_t VALUE_MASK = field_t'((64'd1 << VW) - 64'd1);

  field_t        stored_primes [STAGES];
  int            stored_count;
  sieve_result_t expected_primes [$];

  // Test one candidate against the stored primes; return 1 if it survives
  function automatic logic sieve_candidate(input field_t raw, input logic clear,
                                           output sieve_result_t res);
    field_t cand;
    logic   full;
    cand = raw & VALUE_MASK;
    res  = '0;
    if (clear) stored_count = 0;
    if (cand < 2) return 1'b0;
    for (int i = 0; i < stored_count; i++) begin
      if (stored_primes[i] != 0 && (cand % stored_primes[i]) == 0) return 1'b0;
    end
    full = (stored_count >= STAGES);
    if (!full) begin
      stored_primes[stored_count] = cand;
      stored_count++;
    end
    res.prime      = cand;
    res.unverified = full;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    sieve_result_t res;
    sieve_result_t want;
    if (rst) begin
      stored_count = 0;
      expected_primes.delete();
    end else begin
      // Predict on every accepted input beat
      if (in_valid && !in_stall) begin
        if (sieve_candidate(value, restart, res)) expected_primes.push_back(res);
      end
      // Compare every accepted output beat with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_primes.size() == 0) begin
          $error("prime: expected no result, got %0d (unverified %0b)", prime, unverified);
          fails++;
        end else begin
          want = expected_primes.pop_front();
          if (prime !== want.prime) begin
            $error("prime: expected %0d, got %0d", want.prime, prime);
            fails++;
          end
          if (unverified !== want.unverified) begin
            $error("unverified: expected %0b, got %0b", want.unverified, unverified);
            fails++;
          end
        end
      end
    end
    pending = expected_primes.size();
  end

endmodule

/* verif/tb_prime_sieve_filter_chain.sv */
// Testbench top for prime_sieve_filter_chain: clock, reset, candidate stimulus, output
// stalls and the final verdict. Depends on psfc_pkg, the block and prime_stream_checker.
module tb_prime_sieve_filter_chain;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [psfc_pkg::FIELD_W-1:0] field_t;

  localparam int STAGES      = psfc_pkg::STAGES_DEF;
  localparam int VALUE_WIDTH = psfc_pkg::VALUE_WIDTH_DEF;
  localparam int LATENCY     = VALUE_WIDTH + STAGES + 2;
  localparam int PHASE_ITEMS = 375;

  logic   clk       = 1'b0;
  logic   rst       = 1'b1;
  logic   in_valid  = 1'b0;
  logic   in_stall;
  field_t value     = '0;
  logic   restart   = 1'b0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  field_t prime;
  logic   unverified;

  int fails;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int candidates_sent = 0;
  int phase_idle  [4] = '{0, 55, 0, 20};
  int phase_stall [4] = '{0, 0, 55, 20};

  prime_sieve_filter_chain #(
    .STAGES      (STAGES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .prime      (prime),
    .unverified (unverified)
  );

  prime_stream_checker #(
    .STAGES      (STAGES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) i_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .prime      (prime),
    .unverified (unverified),
    .fails      (fails),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Hold off the candidate channel at random, then present one beat until accepted
  task automatic send_candidate(input field_t v, input logic clear);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    restart  <= clear;
    do @(posedge clk); while (in_stall);
    if (v >= 2) candidates_sent++;
  endtask

  // Drop valid and wait until every predicted prime has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Mostly fresh ascending streams from two, some from a random base, some noise
  task automatic random_candidates(input int count);
    int     kind;
    int     len;
    int     step;
    field_t v;
    while (candidates_sent < count) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        len = $urandom_range(20, 120);
        for (int i = 0; i < len; i++) send_candidate(field_t'(2 + i), i == 0);
      end else if (kind < 80) begin
        len = $urandom_range(10, 40);
        v   = field_t'($urandom_range(2, 65000));
        for (int i = 0; i < len; i++) begin
          send_candidate(v, i == 0);
          step = $urandom_range(1, 4);
          v    = v + field_t'(step);
        end
      end else begin
        len = $urandom_range(5, 20);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(9) == 0) v = field_t'($urandom_range(1));
          else v = field_t'($urandom_range(65535));
          send_candidate(v, $urandom_range(9) == 0);
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Restart on a value below two, send another below two, then the top value twice
    send_candidate(16'd0, 1'b1);
    send_candidate(16'd1, 1'b0);
    send_candidate(16'hFFFF, 1'b0);
    send_candidate(16'hFFFF, 1'b0);
    // Fill the table with the first sixteen primes
    send_candidate(16'd2, 1'b1);
    send_candidate(16'd3, 1'b0);
    send_candidate(16'd5, 1'b0);
    send_candidate(16'd7, 1'b0);
    send_candidate(16'd11, 1'b0);
    send_candidate(16'd13, 1'b0);
    send_candidate(16'd17, 1'b0);
    send_candidate(16'd19, 1'b0);
    send_candidate(16'd23, 1'b0);
    send_candidate(16'd29, 1'b0);
    send_candidate(16'd31, 1'b0);
    send_candidate(16'd37, 1'b0);
    send_candidate(16'd41, 1'b0);
    send_candidate(16'd43, 1'b0);
    send_candidate(16'd47, 1'b0);
    send_candidate(16'd53, 1'b0);
    // Survivors of a full table come out flagged
    send_candidate(16'd59, 1'b0);
    send_candidate(16'hFFFE, 1'b0);
    send_candidate(16'd65521, 1'b0);
    // Restart on a composite, which is then stored
    send_candidate(16'd4, 1'b1);
    send_candidate(16'd8, 1'b0);
    drain_results();

    candidates_sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      random_candidates((ph + 1) * PHASE_ITEMS);
      drain_results();
    end

    stall_pct = 0;
    repeat (2 * LATENCY) @(posedge clk);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
